FILE: hw/rtl/timed_press_release_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// timed press/release sequencer assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef TIMED_PRESS_RELEASE_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_PRESS_RELEASE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define TPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tprs_pkg.sv
// ----------------------------------------------------------------------------
// tprs_pkg
// shared types and constants of the timed press/release sequencer
// ----------------------------------------------------------------------------
package tprs_pkg;

  // widths
  localparam int TIME_W   = 32;
  localparam int DT_W     = 16;
  localparam int CNT_W    = 8;
  localparam int PROG_W   = 17;
  localparam int QF_W     = 16;
  localparam int T10_W    = 36;
  localparam int KPT_W    = 35;
  localparam int DEN_W    = 44;
  localparam int NUM_W    = 45;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;

  // request kinds
  typedef logic [1:0] req_code_t;
  localparam req_code_t REQ_TICK   = 2'd0;
  localparam req_code_t REQ_START  = 2'd1;
  localparam req_code_t REQ_CANCEL = 2'd2;
  localparam req_code_t REQ_RESET  = 2'd3;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_PRESS   = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4,
    PH_FAILED  = 3'd5
  } phase_t;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_SETTLE      = 3'd0;
  localparam cfg_addr_t CFG_PRESS_HOLD  = 3'd1;
  localparam cfg_addr_t CFG_REL_HOLD    = 3'd2;
  localparam cfg_addr_t CFG_DEBOUNCE    = 3'd3;
  localparam cfg_addr_t CFG_TIMEOUT     = 3'd4;
  localparam cfg_addr_t CFG_TARGET      = 3'd5;
  localparam cfg_addr_t CFG_CONTACT_EN  = 3'd6;
  localparam cfg_addr_t CFG_ACT_PRESENT = 3'd7;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [DT_W-1:0] elapsed;
    logic            contact;
  } req_item_t;

  typedef struct packed {
    logic              finished;
    logic              success;
    logic              drive_valid;
    logic              pusher_pressed;
    logic [PROG_W-1:0] progress;
    logic [2:0]        phase;
    logic [CNT_W-1:0]  presses_done_count;
  } rsp_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] settle_time;
    logic [TIME_W-1:0] press_hold_time;
    logic [TIME_W-1:0] release_hold_time;
    logic [TIME_W-1:0] debounce_time;
    logic [TIME_W-1:0] timeout_time;
    logic [CNT_W-1:0]  press_count_target;
    logic              contact_enable;
    logic              actuator_present;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic decode;
    logic prep;
    logic mul_num;
    logic mul_den;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active_tick;
    logic timeout;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/tprs_cfg.sv
// ----------------------------------------------------------------------------
// tprs_cfg
// configuration register file, written through the cfg write channel
// ----------------------------------------------------------------------------
module tprs_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tprs_pkg::cfg_addr_t cfg_index,
  input  logic [31:0]         cfg_data,
  output tprs_pkg::cfg_t      cfg
);
  import tprs_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_time        <= 32'd200000;
      cfg.press_hold_time    <= 32'd300000;
      cfg.release_hold_time  <= 32'd300000;
      cfg.debounce_time      <= 32'd20000;
      cfg.timeout_time       <= 32'd0;
      cfg.press_count_target <= 8'd3;
      cfg.contact_enable     <= 1'b0;
      cfg.actuator_present   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETTLE:      cfg.settle_time        <= cfg_data;
        CFG_PRESS_HOLD:  cfg.press_hold_time    <= cfg_data;
        CFG_REL_HOLD:    cfg.release_hold_time  <= cfg_data;
        CFG_DEBOUNCE:    cfg.debounce_time      <= cfg_data;
        CFG_TIMEOUT:     cfg.timeout_time       <= cfg_data;
        CFG_TARGET:      cfg.press_count_target <= cfg_data[CNT_W-1:0];
        CFG_CONTACT_EN:  cfg.contact_enable     <= cfg_data[0];
        CFG_ACT_PRESENT: cfg.actuator_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tprs_div.sv
// ----------------------------------------------------------------------------
// tprs_div
// restoring divider for progress, one quotient bit per cycle, clamps at 1.0
// ----------------------------------------------------------------------------
module tprs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tprs_pkg::NUM_W-1:0]    num,
  input  logic [tprs_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [tprs_pkg::PROG_W-1:0]   quot
);
  import tprs_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [QF_W-1:0]   qbits;
  logic              sat;

  logic [DEN_W:0]    rem2;
  logic [DEN_W-1:0]  diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // one restoring step
  always_comb begin
    rem2     = {rem, 1'b0};
    diff     = rem2[DEN_W-1:0] - dsr;
    ge       = rem2 >= {1'b0, dsr};
    rem_next = ge ? diff : rem2[DEN_W-1:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(QF_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[DEN_W-1:0];
      dsr   <= den;
      qbits <= '0;
      sat   <= num >= {1'b0, den};
    end else if (busy) begin
      rem   <= rem_next;
      qbits <= {qbits[QF_W-2:0], ge};
    end
  end

  // a ratio of one or more reads as exactly 1.0
  assign quot = sat ? PROG_ONE : {1'b0, qbits};

endmodule

FILE: hw/rtl/tprs_dp.sv
// ----------------------------------------------------------------------------
// tprs_dp
// sequencer datapath: run state, timers, progress arithmetic, result register
// ----------------------------------------------------------------------------
module tprs_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_take,
  input  tprs_pkg::req_item_t    req_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output tprs_pkg::rsp_item_t    rsp_data,
  input  tprs_pkg::cfg_t         cfg,
  input  tprs_pkg::dp_cmd_t      cmd,
  output tprs_pkg::dp_status_t   status
);
  import tprs_pkg::*;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [DT_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + (TIME_W+1)'(b);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // run state
  phase_t            phase_reg;
  logic              running;
  logic              done_flag;
  logic              ok_flag;
  logic [CNT_W-1:0]  press_counter;
  logic [TIME_W-1:0] phase_timer;
  logic [TIME_W-1:0] run_timer;
  logic [TIME_W-1:0] stable_timer;
  logic              prev_contact;
  logic [PROG_W-1:0] progress_reg;
  logic              timeout;

  // working registers
  req_item_t         item;
  logic [T10_W-1:0]  t10;
  logic [KPT_W-1:0]  kpt;
  logic              t_zero;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;

  logic              active_tick;
  logic              out_free;
  logic [TIME_W-1:0] pt_sat;
  logic [TIME_W-1:0] rt_sat;
  logic [TIME_W-1:0] st_sat;
  logic              to_hit;

  logic [TIME_W-1:0] t_sel;
  logic [TIME_W-1:0] pt_min;
  logic [KPT_W-1:0]  pt_ext;
  logic [T10_W-1:0]  t10_next;
  logic [KPT_W-1:0]  kpt_next;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  mul_b;
  logic [DEN_W-1:0]  prod;

  logic              div_done;
  logic [PROG_W-1:0] div_q;

  phase_t            phase_next;
  logic              running_next;
  logic              done_next;
  logic              ok_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_inc;
  logic [TIME_W-1:0] phase_timer_next;
  logic [TIME_W-1:0] run_timer_next;
  logic [TIME_W-1:0] stable_next;
  logic              prev_next;
  logic [PROG_W-1:0] progress_next;
  logic              drv;
  logic              pressed;
  logic              press_ok;
  rsp_item_t         rsp_next;

  assign active_tick = (item.req_type == REQ_TICK) && running;
  assign out_free    = !rsp_valid || !rsp_stall;

  assign status.active_tick = active_tick;
  assign status.timeout     = timeout;
  assign status.div_done    = div_done;
  assign status.out_free    = out_free;

  // timer advance and timeout check for a tick
  always_comb begin
    pt_sat = sat_add(phase_timer, item.elapsed);
    rt_sat = sat_add(run_timer, item.elapsed);
    st_sat = sat_add(stable_timer, item.elapsed);
    to_hit = (cfg.timeout_time != '0) && (rt_sat >= cfg.timeout_time);
  end

  // phase length and weight for the progress fraction
  always_comb begin
    case (phase_reg)
      PH_SETTLE:  t_sel = cfg.settle_time;
      PH_PRESS:   t_sel = cfg.press_hold_time;
      PH_RELEASE: t_sel = cfg.release_hold_time;
      default:    t_sel = '0;
    endcase
    pt_min   = (phase_timer < t_sel) ? phase_timer : t_sel;
    pt_ext   = KPT_W'(pt_min);
    case (phase_reg)
      PH_SETTLE:  kpt_next = pt_ext;
      PH_PRESS:   kpt_next = (pt_ext << 2) + pt_ext;
      PH_RELEASE: kpt_next = pt_ext << 2;
      default:    kpt_next = '0;
    endcase
    t10_next = (T10_W'(t_sel) << 3) + (T10_W'(t_sel) << 1);
  end

  // shared multiplier, count term first then the denominator
  always_comb begin
    total = (cfg.press_count_target == '0) ? CNT_W'(1) : cfg.press_count_target;
    mul_b = cmd.mul_num ? press_counter : total;
    prod  = DEN_W'(t10) * DEN_W'(mul_b);
  end

  tprs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  // outcome of the request
  always_comb begin
    phase_next       = phase_reg;
    running_next     = running;
    done_next        = done_flag;
    ok_next          = ok_flag;
    count_next       = press_counter;
    phase_timer_next = phase_timer;
    run_timer_next   = run_timer;
    stable_next      = stable_timer;
    prev_next        = prev_contact;
    progress_next    = progress_reg;
    drv              = 1'b0;
    pressed          = 1'b0;
    press_ok         = cfg.contact_enable && item.contact &&
                       (stable_timer >= cfg.debounce_time);
    count_inc        = (press_counter != {CNT_W{1'b1}}) ? press_counter + 1'b1
                                                        : press_counter;
    case (item.req_type)
      REQ_TICK: begin
        if (running) begin
          drv = cfg.actuator_present;
          if (timeout) begin
            phase_next   = PH_FAILED;
            running_next = 1'b0;
            done_next    = 1'b1;
            ok_next      = 1'b0;
          end else begin
            progress_next = div_q;
            case (phase_reg)
              PH_SETTLE: begin
                if (phase_timer >= cfg.settle_time) begin
                  pressed          = 1'b1;
                  phase_next       = PH_PRESS;
                  phase_timer_next = '0;
                  stable_next      = '0;
                  prev_next        = 1'b0;
                end
              end
              PH_PRESS: begin
                if ((phase_timer >= cfg.press_hold_time) || press_ok) begin
                  phase_next       = PH_RELEASE;
                  phase_timer_next = '0;
                  stable_next      = '0;
                  prev_next        = 1'b0;
                end else begin
                  pressed = 1'b1;
                end
              end
              PH_RELEASE: begin
                if (phase_timer >= cfg.release_hold_time) begin
                  count_next       = count_inc;
                  phase_timer_next = '0;
                  stable_next      = '0;
                  prev_next        = 1'b0;
                  if (count_inc >= cfg.press_count_target) begin
                    running_next  = 1'b0;
                    done_next     = 1'b1;
                    ok_next       = 1'b1;
                    progress_next = PROG_ONE;
                    phase_next    = PH_DONE;
                  end else begin
                    pressed    = 1'b1;
                    phase_next = PH_PRESS;
                  end
                end
              end
              PH_DONE, PH_FAILED: ;
              default: begin
                // running with no active phase cancels
                phase_next   = PH_FAILED;
                running_next = 1'b0;
                done_next    = 1'b1;
                ok_next      = 1'b0;
              end
            endcase
          end
        end
      end
      REQ_START: begin
        if (!cfg.actuator_present) begin
          running_next  = 1'b0;
          done_next     = 1'b1;
          ok_next       = 1'b0;
          progress_next = '0;
          phase_next    = PH_FAILED;
        end else begin
          drv              = 1'b1;
          running_next     = 1'b1;
          done_next        = 1'b0;
          ok_next          = 1'b0;
          count_next       = '0;
          run_timer_next   = '0;
          progress_next    = '0;
          phase_next       = PH_SETTLE;
          phase_timer_next = '0;
          stable_next      = '0;
          prev_next        = 1'b0;
        end
      end
      REQ_CANCEL: begin
        drv          = cfg.actuator_present;
        running_next = 1'b0;
        done_next    = 1'b1;
        ok_next      = 1'b0;
        phase_next   = PH_FAILED;
      end
      default: begin
        // reset request
        drv              = cfg.actuator_present;
        running_next     = 1'b0;
        done_next        = 1'b1;
        ok_next          = 1'b1;
        count_next       = '0;
        phase_timer_next = '0;
        run_timer_next   = '0;
        stable_next      = '0;
        prev_next        = 1'b0;
        progress_next    = '0;
        phase_next       = PH_IDLE;
      end
    endcase

    rsp_next.finished           = done_next || !running_next;
    rsp_next.success            = ok_next;
    rsp_next.drive_valid        = drv;
    rsp_next.pusher_pressed     = drv && pressed;
    rsp_next.progress           = progress_next;
    rsp_next.phase              = phase_next;
    rsp_next.presses_done_count = count_next;
  end

  // run state, timers and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      running       <= 1'b0;
      done_flag     <= 1'b1;
      ok_flag       <= 1'b1;
      press_counter <= '0;
      phase_timer   <= '0;
      run_timer     <= '0;
      stable_timer  <= '0;
      prev_contact  <= 1'b0;
      progress_reg  <= '0;
      timeout       <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.decode && active_tick) begin
        phase_timer <= pt_sat;
        run_timer   <= rt_sat;
        timeout     <= to_hit;
        if (cfg.contact_enable && !to_hit) begin
          if (item.contact == prev_contact) begin
            stable_timer <= st_sat;
          end else begin
            stable_timer <= '0;
            prev_contact <= item.contact;
          end
        end
      end
      if (cmd.commit && out_free) begin
        phase_reg     <= phase_next;
        running       <= running_next;
        done_flag     <= done_next;
        ok_flag       <= ok_next;
        press_counter <= count_next;
        phase_timer   <= phase_timer_next;
        run_timer     <= run_timer_next;
        stable_timer  <= stable_next;
        prev_contact  <= prev_next;
        progress_reg  <= progress_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture, progress operands and result payload
  always_ff @(posedge clk) begin
    if (req_take) begin
      item <= req_data;
    end
    if (cmd.prep) begin
      t10    <= t10_next;
      kpt    <= kpt_next;
      t_zero <= (t_sel == '0);
    end
    if (cmd.mul_num) begin
      num <= t_zero ? NUM_W'(press_counter) : NUM_W'(prod) + NUM_W'(kpt);
    end
    if (cmd.mul_den) begin
      den <= t_zero ? DEN_W'(total) : prod;
    end
    if (cmd.commit && out_free) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

FILE: hw/rtl/tprs_ctrl.sv
// ----------------------------------------------------------------------------
// tprs_ctrl
// request sequencer: decode, progress operands, divide, commit
// ----------------------------------------------------------------------------
module tprs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_take,
  output logic                  req_stall,
  input  tprs_pkg::dp_status_t  status,
  output tprs_pkg::dp_cmd_t     cmd
);
  import tprs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PREP,
    S_MULN,
    S_MULD,
    S_DIVST,
    S_DIVW,
    S_COMMIT
  } state_t;

  state_t state;

  // state, stall and command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
      cmd       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            state     <= S_DECODE;
            req_stall <= 1'b1;
            cmd       <= '{decode: 1'b1, default: 1'b0};
          end else begin
            cmd <= '0;
          end
        end
        S_DECODE: begin
          if (status.active_tick) begin
            state <= S_PREP;
            cmd   <= '{prep: 1'b1, default: 1'b0};
          end else begin
            state <= S_COMMIT;
            cmd   <= '{commit: 1'b1, default: 1'b0};
          end
        end
        S_PREP: begin
          if (status.timeout) begin
            state <= S_COMMIT;
            cmd   <= '{commit: 1'b1, default: 1'b0};
          end else begin
            state <= S_MULN;
            cmd   <= '{mul_num: 1'b1, default: 1'b0};
          end
        end
        S_MULN: begin
          state <= S_MULD;
          cmd   <= '{mul_den: 1'b1, default: 1'b0};
        end
        S_MULD: begin
          state <= S_DIVST;
          cmd   <= '{div_start: 1'b1, default: 1'b0};
        end
        S_DIVST: begin
          state <= S_DIVW;
          cmd   <= '0;
        end
        S_DIVW: begin
          if (status.div_done) begin
            state <= S_COMMIT;
            cmd   <= '{commit: 1'b1, default: 1'b0};
          end else begin
            cmd <= '0;
          end
        end
        S_COMMIT: begin
          // hold until the result register has room
          if (status.out_free) begin
            state     <= S_IDLE;
            req_stall <= 1'b0;
            cmd       <= '0;
          end else begin
            cmd <= '{commit: 1'b1, default: 1'b0};
          end
        end
        default: begin
          state     <= S_IDLE;
          req_stall <= 1'b0;
          cmd       <= '0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/timed_press_release_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_press_release_sequencer_unit
// press/release sequencer with configurable timing, debounce and timeout
// ----------------------------------------------------------------------------
// Each accepted request gives exactly one result. Start, cancel, reset and
// ticks that arrive while no run is active go from decode straight to
// commit. A tick during a run passes decode, operand prep, the multiplier
// passes, the divide and commit, or goes from prep to commit when it hits
// the timeout: the progress fraction comes from a restoring divider that
// retires one quotient bit per cycle, after a shared 36x8 multiplier forms
// its operands in two passes. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
module timed_press_release_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  tprs_pkg::req_item_t  req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output tprs_pkg::rsp_item_t  rsp_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tprs_pkg::cfg_addr_t  cfg_index,
  input  logic [31:0]          cfg_data
);
  import tprs_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_take;

  assign req_take = req_valid && !req_stall;

  tprs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tprs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_take  (req_take),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tprs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_take  (req_take),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: hw/rtl/tprs_port_check.sv
// ----------------------------------------------------------------------------
// tprs_port_check
// port-level checks on the sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_press_release_sequencer_unit_assert.svh"

module tprs_port_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input tprs_pkg::rsp_item_t  rsp_data
);
  import tprs_pkg::*;

  // a taken request keeps the block busy for at least the next cycle
  `TPRS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "no stall after request")

  // a new result only comes out of a request in work
  `TPRS_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "result without request")

  // a stalled result holds
  `TPRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed under stall")

  // finished phases report finished, success only when done
  `TPRS_ASSERT_NOW(a_end_flags, rsp_valid && (rsp_data.phase == PH_DONE || rsp_data.phase == PH_FAILED), rsp_data.finished && (rsp_data.success == (rsp_data.phase == PH_DONE)), "end phase flags wrong")

endmodule

bind timed_press_release_sequencer_unit tprs_port_check u_port_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
